[hdl/crfs_pkg.sv]
// ----------------------------------------------------------------------------
// crfs_pkg
// Shared types and constants for the circle raster frame store.
// ----------------------------------------------------------------------------
package crfs_pkg;

	// Store geometry; the cell address is {row, column}
	localparam int MAX_COLUMNS = 256;
	localparam int MAX_ROWS    = 256;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int ADDR_W      = COL_W + ROW_W;
	localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
	localparam int CNT_W       = 9;

	// Fixed-point geometry: 8 fraction bits
	localparam int FRAC_W   = 8;
	localparam int COORD_W  = 20;
	localparam int RAD_W    = 18;
	localparam int DIFF_W   = COORD_W + 2;
	localparam int ABS_W    = 20;
	localparam int SQ_W     = 2 * ABS_W;
	localparam int D2_W     = SQ_W + 1;
	localparam int RSQ_W    = 2 * (RAD_W + 1);

	// Command codes carried in tuser
	typedef enum logic [1:0] {
		FN_CLEAR   = 2'd0,
		FN_OUTLINE = 2'd1,
		FN_FILLED  = 2'd2,
		FN_READ    = 2'd3
	} crfs_func_t;

	// Register indexes, paddr[3:2]
	localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BACKGROUND  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SETUP,
		ST_PAINT,
		ST_DRAIN,
		ST_RD_MEM,
		ST_RD_OUT
	} crfs_state_t;

endpackage

[hdl/circle_raster_frame_store_core.sv]
// ----------------------------------------------------------------------------
// circle_raster_frame_store_core
// Character frame store with clear, circle paint and cell read commands.
// ----------------------------------------------------------------------------
// Commands arrive as words on the s_ channel, the command code in s_tuser.
// Clear writes background_char into all 65536 cells, one per cycle. An
// outline or filled circle first squares the radius bounds in ST_SETUP,
// then sweeps the grid cells in row order through a three-stage distance
// pipeline (difference, squares, sum and compare) that tests one cell a
// cycle, writes the cells it hits and then drains in ST_DRAIN. Clear and
// paint share the single write port of the store and give no result. A
// read passes its word through the store data register and then the output
// register to the m_ channel, and the next word is taken once the result is
// in the output register; the cell character is in m_tdata, m_tlast marks
// the last grid column.
// One command is worked at a time; s_tready is high whenever the block is
// idle, also while a result still waits in the output register. A read
// that finds the output register full holds until m_tready takes the word.
// Reset clears the control state and the registers to 256, 256 and 32; the
// store itself holds no defined data until the first clear or paint.
// Registers: 0 grid_width, 1 grid_height, 2 background_char (APB, 4-byte).
// ----------------------------------------------------------------------------
module circle_raster_frame_store_core
	import crfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// command word
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata from bit 0: center_x[19:0], center_y[39:20], circle_radius[57:40],
	// paint_char[65:58], cell_x[73:66], cell_y[81:74], zero fill[87:82]
	input  logic [87:0] s_tdata,
	// tuser: func[1:0]
	input  logic [1:0]  s_tuser,
	// result word
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: cell_char[7:0]
	output logic [7:0]  m_tdata,
	// tlast: row_end
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	crfs_state_t state_q, state_d;

	logic [CNT_W-1:0] grid_width_q, grid_height_q;
	logic [7:0]       bg_char_q;
	logic [CNT_W-1:0] used_cols, used_rows;

	// command registers
	logic                      outline_q;
	logic signed [COORD_W-1:0] cx_q, cy_q;
	logic [RAD_W-1:0]          rad_q;
	logic [7:0]                char_q;
	logic [RSQ_W-1:0]          r2_q, hi_q, lo_q;
	logic                      has_lo_q;

	// sweep counters
	logic [ADDR_W-1:0] clr_addr_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              last_col, last_row;

	// distance pipeline
	logic              valid_s1, valid_s2;
	logic [ABS_W-1:0]  dx_s1, dy_s1;
	logic [ADDR_W-1:0] addr_s1, addr_s2;
	logic [SQ_W-1:0]   dx2_s2, dy2_s2;
	logic [D2_W-1:0]   d2_c;
	logic              hit_c;

	// read path
	logic [ADDR_W-1:0] rd_addr_q;
	logic [7:0]        rd_data_q;
	logic              in_grid_q, rend_q;
	logic              m_tvalid_q;
	logic [7:0]        out_char_q;
	logic              out_last_q;

	// control
	logic              accept, load_out, paint_issue, clr_wr, cfg_wr;
	logic [COL_W-1:0]  in_x;
	logic [ROW_W-1:0]  in_y;
	logic              in_grid_c, rend_c;

	// memory write port
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;

	logic [7:0] frame_mem [CELLS];

	logic signed [DIFF_W-1:0] dx_c, dy_c;
	logic [RAD_W:0]           rad_hi_c;
	logic [RAD_W-1:0]         rad_lo_c;

	// Saturate the grid to the store size
	assign used_cols = (grid_width_q > CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : grid_width_q;
	assign used_rows = (grid_height_q > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : grid_height_q;

	assign last_col = ({1'b0, col_q} == used_cols - CNT_W'(1));
	assign last_row = ({1'b0, row_q} == used_rows - CNT_W'(1));

	assign accept = s_tvalid && s_tready;
	assign in_x   = s_tdata[73:66];
	assign in_y   = s_tdata[81:74];
	assign in_grid_c = ({1'b0, in_x} < used_cols) && ({1'b0, in_y} < used_rows);
	assign rend_c    = ({1'b0, in_x} + CNT_W'(1)) == used_cols;

	// Next state and sequencing strobes
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		load_out    = 1'b0;
		paint_issue = 1'b0;
		clr_wr      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (crfs_func_t'(s_tuser))
						FN_CLEAR:   state_d = ST_CLEAR;
						FN_OUTLINE: state_d = ST_SETUP;
						FN_FILLED:  state_d = ST_SETUP;
						FN_READ:    state_d = ST_RD_MEM;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				clr_wr = 1'b1;
				if (clr_addr_q == '1) state_d = ST_IDLE;
			end
			ST_SETUP: begin
				if (used_cols == '0 || used_rows == '0) state_d = ST_IDLE;
				else state_d = ST_PAINT;
			end
			ST_PAINT: begin
				paint_issue = 1'b1;
				if (last_col && last_row) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!valid_s1 && !valid_s2) state_d = ST_IDLE;
			end
			ST_RD_MEM: begin
				state_d = ST_RD_OUT;
			end
			ST_RD_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold the state, sweep counters and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			clr_addr_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= paint_issue;
			valid_s2 <= valid_s1;
			if (accept) begin
				clr_addr_q <= '0;
				col_q      <= '0;
				row_q      <= '0;
			end else begin
				if (clr_wr) clr_addr_q <= clr_addr_q + ADDR_W'(1);
				if (paint_issue) begin
					if (last_col) begin
						col_q <= '0;
						row_q <= row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
			end
			if (load_out) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Capture the command word
	always_ff @(posedge clk) begin
		if (accept) begin
			outline_q <= (crfs_func_t'(s_tuser) == FN_OUTLINE);
			cx_q      <= s_tdata[19:0];
			cy_q      <= s_tdata[39:20];
			rad_q     <= s_tdata[57:40];
			char_q    <= s_tdata[65:58];
			rd_addr_q <= {in_y, in_x};
			in_grid_q <= in_grid_c;
			rend_q    <= rend_c;
		end
	end

	// Square the radius bounds once per circle
	assign rad_hi_c = {1'b0, rad_q} + (RAD_W+1)'(1 << FRAC_W);
	assign rad_lo_c = rad_q - RAD_W'(1 << FRAC_W);

	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			r2_q     <= RSQ_W'(rad_q) * RSQ_W'(rad_q);
			hi_q     <= RSQ_W'(rad_hi_c) * RSQ_W'(rad_hi_c);
			lo_q     <= RSQ_W'(rad_lo_c) * RSQ_W'(rad_lo_c);
			has_lo_q <= (rad_q >= RAD_W'(1 << FRAC_W));
		end
	end

	// Stage 1: distance of the cell position to the centre
	assign dx_c = $signed({{(DIFF_W-COL_W-FRAC_W){1'b0}}, col_q, {FRAC_W{1'b0}}})
		- $signed({{(DIFF_W-COORD_W){cx_q[COORD_W-1]}}, cx_q});
	assign dy_c = $signed({{(DIFF_W-ROW_W-FRAC_W){1'b0}}, row_q, {FRAC_W{1'b0}}})
		- $signed({{(DIFF_W-COORD_W){cy_q[COORD_W-1]}}, cy_q});

	always_ff @(posedge clk) begin
		dx_s1   <= dx_c[DIFF_W-1] ? ABS_W'(-dx_c) : ABS_W'(dx_c);
		dy_s1   <= dy_c[DIFF_W-1] ? ABS_W'(-dy_c) : ABS_W'(dy_c);
		addr_s1 <= {row_q, col_q};
	end

	// Stage 2: squares
	always_ff @(posedge clk) begin
		dx2_s2  <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
		dy2_s2  <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
		addr_s2 <= addr_s1;
	end

	// Stage 3: sum and compare against the radius bounds
	assign d2_c = {1'b0, dx2_s2} + {1'b0, dy2_s2};

	always_comb begin
		if (outline_q)
			hit_c = (d2_c < D2_W'(hi_q)) && (!has_lo_q || d2_c > D2_W'(lo_q));
		else
			hit_c = (d2_c <= D2_W'(r2_q));
	end

	// Select the store write: clear sweep or painted cell
	always_comb begin
		if (clr_wr) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = bg_char_q;
		end else begin
			wr_en   = valid_s2 && hit_c;
			wr_addr = addr_s2;
			wr_data = char_q;
		end
	end

	// Frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) frame_mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		rd_data_q <= frame_mem[rd_addr_q];
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_char_q <= in_grid_q ? rd_data_q : bg_char_q;
			out_last_q <= in_grid_q && rend_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;

	// Configuration registers
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= CNT_W'(256);
			grid_height_q <= CNT_W'(256);
			bg_char_q     <= 8'd32;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[CNT_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= pwdata[CNT_W-1:0];
				REG_BACKGROUND:  bg_char_q     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_GRID_WIDTH:  prdata = {{(32-CNT_W){1'b0}}, grid_width_q};
			REG_GRID_HEIGHT: prdata = {{(32-CNT_W){1'b0}}, grid_height_q};
			REG_BACKGROUND:  prdata = {24'd0, bg_char_q};
			default:         prdata = 32'd0;
		endcase
	end

`ifndef NO_ASSERTIONS
	// Painted cells lie inside the grid columns
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && hit_c && !clr_wr) |-> ({1'b0, addr_s2[COL_W-1:0]} < used_cols))
		else $error("paint write outside grid columns");

	// Clear and paint never share the write port
	assert property (@(posedge clk) disable iff (!arst_n)
		clr_wr |-> (!valid_s1 && !valid_s2))
		else $error("clear overlaps paint pipeline");

	// Idle means the distance pipeline has drained
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!valid_s1 && !valid_s2))
		else $error("pipeline busy while idle");

	// A blocked read result waits in place
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_OUT && m_tvalid_q && !m_tready) |=> (state_q == ST_RD_OUT))
		else $error("read result dropped while output blocked");
`endif

endmodule

[tb/circle_raster_frame_store_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_raster_frame_store_core_tb
// Drives clear, outline, filled circle and cell read commands into the frame
// store under several grid settings. A shadow copy of the store predicts
// every read word, and each word is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module circle_raster_frame_store_core_tb
	import crfs_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int unsigned IDLE_PCT    = 18;
	localparam int          ONE_CELL    = 1 << FRAC_W;
	localparam logic [1:0]  REG_SPARE   = 2'd3;
	localparam logic [7:0]  CH_ONE      = "1";
	localparam logic [7:0]  CH_RING     = "c";
	localparam logic [7:0]  CH_DISC     = "C";
	localparam logic [7:0]  CH_DOT      = ".";

	// Shadow of the store and registers; holds the read words still due
	class frame_store_board;
		typedef struct packed {
			logic [7:0] cell_char;
			logic       row_end;
		} cell_word_t;

		logic [7:0]  shadow [CELLS];
		cell_word_t  reads_due [$];
		logic [8:0]  width_reg  = 9'd256;
		logic [8:0]  height_reg = 9'd256;
		logic [7:0]  background = 8'd32;
		int unsigned errors     = 0;

		function int unsigned used_cols();
			return (width_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(width_reg);
		endfunction

		function int unsigned used_rows();
			return (height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_GRID_WIDTH:  width_reg  = value[8:0];
				REG_GRID_HEIGHT: height_reg = value[8:0];
				REG_BACKGROUND:  background = value[7:0];
				default: ;
			endcase
		endfunction

		// Exact squared-distance test over the visible grid
		function void paint(bit ring, longint cx, longint cy, longint rad, logic [7:0] ch);
			longint r2, hi, lo, dx, dy, d2;
			bit     hit;
			r2 = rad * rad;
			hi = (rad + ONE_CELL) * (rad + ONE_CELL);
			// no inner bound below one cell of radius
			lo = (rad >= ONE_CELL) ? (rad - ONE_CELL) * (rad - ONE_CELL) : -1;
			for (int row = 0; row < used_rows(); row++) begin
				dy = longint'(row) * ONE_CELL - cy;
				for (int col = 0; col < used_cols(); col++) begin
					dx  = longint'(col) * ONE_CELL - cx;
					d2  = dx * dx + dy * dy;
					hit = ring ? (d2 < hi && d2 > lo) : (d2 <= r2);
					if (hit) begin
						shadow[row * MAX_COLUMNS + col] = ch;
					end
				end
			end
		endfunction

		// Apply one accepted command word
		function void note_command(crfs_func_t f, logic [19:0] cx, logic [19:0] cy,
				logic [17:0] rad, logic [7:0] pc, logic [7:0] x, logic [7:0] y);
			cell_word_t w;
			case (f)
				FN_CLEAR: begin
					foreach (shadow[i]) shadow[i] = background;
				end
				FN_OUTLINE, FN_FILLED: begin
					paint(f == FN_OUTLINE, longint'($signed(cx)), longint'($signed(cy)),
						longint'(rad), pc);
				end
				default: begin
					if (int'(x) < used_cols() && int'(y) < used_rows()) begin
						w.cell_char = shadow[int'(y) * MAX_COLUMNS + int'(x)];
						w.row_end   = (int'(x) + 1 == used_cols());
					end else begin
						w.cell_char = background;
						w.row_end   = 1'b0;
					end
					reads_due.push_back(w);
				end
			endcase
		endfunction

		// Compare one result word against the oldest read due
		function void check_read(logic [7:0] ch, logic last);
			cell_word_t want;
			if (reads_due.size() == 0) begin
				$error("result word with no read outstanding: cell_char %0d, row_end %0b",
					ch, last);
				errors++;
				return;
			end
			want = reads_due.pop_front();
			if (ch !== want.cell_char) begin
				$error("cell_char mismatch: expected %0d, actual %0d", want.cell_char, ch);
				errors++;
			end
			if (last !== want.row_end) begin
				$error("row_end mismatch: expected %0b, actual %0b", want.row_end, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [87:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	frame_store_board board;
	logic             calm;
	int unsigned      settle_cycles;
	int unsigned      clears_left;
	int unsigned      cycle_count = 0;

	circle_raster_frame_store_core uut (.*);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Stall the result side at random, never during a calm stretch
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// Check every result word taken
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_read(m_tdata, m_tlast);
		end
	end

	// Offer one command word, hold until taken, then update the shadow
	task automatic send_cmd(input crfs_func_t f, input logic [19:0] cx, input logic [19:0] cy,
			input logic [17:0] rad, input logic [7:0] pc, input logic [7:0] x,
			input logic [7:0] y);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {6'd0, y, x, pc, rad, cy, cx};
		do @(posedge clk); while (!s_tready);
		board.note_command(f, cx, cy, rad, pc, x, y);
		case (f)
			FN_CLEAR:              settle_cycles = CELLS + 256;
			FN_OUTLINE, FN_FILLED: settle_cycles = board.used_cols() * board.used_rows() + 256;
			default:               settle_cycles = 8;
		endcase
	endtask

	// Setup then access cycle; the bus is released by apb_release
	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.write_reg(idx, value);
	endtask

	task automatic apb_release();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Drop valid, drain all reads, then let a pending clear or paint finish
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (board.reads_due.size() != 0) @(posedge clk);
		repeat (settle_cycles) @(posedge clk);
		settle_cycles = 0;
	endtask

	// One grid setting followed by random commands; ends idle
	task automatic run_phase(input logic [8:0] w, input logic [8:0] h, input logic [7:0] bg,
			input int unsigned items, input int unsigned draws, input logic quiet,
			input bit hold_mid);
		crfs_func_t  f;
		logic [19:0] cx, cy;
		logic [17:0] rad;
		logic [7:0]  pc, x, y;
		logic [31:0] word;
		int unsigned cols, rows, span, pick, draws_left;

		// program the grid; upper data bits carry junk
		word = $urandom;
		word[8:0] = w;
		apb_write(REG_GRID_WIDTH, word);
		word = $urandom;
		word[8:0] = h;
		apb_write(REG_GRID_HEIGHT, word);
		word = $urandom;
		word[7:0] = bg;
		apb_write(REG_BACKGROUND, word);
		apb_write(REG_SPARE, $urandom);
		apb_release();
		calm <= quiet;

		cols       = board.used_cols();
		rows       = board.used_rows();
		span       = ((cols > rows) ? cols : rows) + 1;
		draws_left = draws;
		for (int n = 0; n < items; n++) begin
			if (hold_mid && n == items / 2) begin
				wait_idle();
			end
			cx   = 20'($urandom);
			cy   = 20'($urandom);
			rad  = 18'($urandom);
			pc   = 8'($urandom);
			x    = 8'($urandom);
			y    = 8'($urandom);
			pick = $urandom_range(99);
			if (pick < 6 && clears_left != 0) begin
				f = FN_CLEAR;
				clears_left--;
			end else if (pick < 50 && draws_left != 0) begin
				f = $urandom_range(1) ? FN_OUTLINE : FN_FILLED;
				draws_left--;
				// mostly circles near the grid, the rest full-range noise
				if ($urandom_range(99) < 80) begin
					cx  = 20'($urandom_range((cols + 2) * ONE_CELL) - ONE_CELL);
					cy  = 20'($urandom_range((rows + 2) * ONE_CELL) - ONE_CELL);
					rad = 18'($urandom_range(1) ? $urandom_range(4 * ONE_CELL)
						: $urandom_range(span * ONE_CELL));
				end
			end else begin
				f = FN_READ;
				if (cols != 0 && rows != 0 && $urandom_range(99) < 75) begin
					x = 8'($urandom_range(cols - 1));
					y = 8'($urandom_range(rows - 1));
				end
			end
			send_cmd(f, cx, cy, rad, pc, x, y);
		end
		wait_idle();
	endtask

	initial begin
		board         = new();
		settle_cycles = 0;
		clears_left   = 3;
		arst_n   <= 1'b0;
		calm     <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= FN_CLEAR;
		m_tready <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: small grid, store cleared before any read
		apb_write(REG_GRID_WIDTH, 32'd20);
		apb_write(REG_GRID_HEIGHT, 32'd12);
		apb_write(REG_BACKGROUND, {24'd0, CH_DOT});
		apb_release();
		send_cmd(FN_CLEAR, 20'd0, 20'd0, 18'd0, 8'd0, 8'd0, 8'd0);
		send_cmd(FN_READ, 20'd0, 20'd0, 18'd0, 8'd0, 8'd0, 8'd0);
		send_cmd(FN_READ, 20'd0, 20'd0, 18'd0, 8'd0, 8'd19, 8'd11);
		send_cmd(FN_READ, 20'd0, 20'd0, 18'd0, 8'd0, 8'd20, 8'd0);
		send_cmd(FN_READ, 20'd0, 20'd0, 18'd0, 8'd0, 8'd255, 8'd255);
		// extreme centers and radius, far from the grid
		send_cmd(FN_FILLED, 20'h7FFFF, 20'h80000, 18'h3FFFF, 8'hFF, 8'd0, 8'd0);
		send_cmd(FN_OUTLINE, 20'h80000, 20'h7FFFF, 18'h3FFFF, 8'h00, 8'd0, 8'd0);
		// disc whose edge lands exactly on cell centers
		send_cmd(FN_FILLED, 20'(10 * ONE_CELL), 20'(6 * ONE_CELL), 18'(4 * ONE_CELL),
			CH_DISC, 8'd0, 8'd0);
		// ring around a half-cell center
		send_cmd(FN_OUTLINE, 20'(5 * ONE_CELL + 128), 20'(5 * ONE_CELL + 128),
			18'(3 * ONE_CELL), CH_RING, 8'd0, 8'd0);
		// ring under one cell of radius: no inner bound
		send_cmd(FN_OUTLINE, 20'(15 * ONE_CELL), 20'(3 * ONE_CELL), 18'd100, CH_ONE,
			8'd0, 8'd0);
		// zero radius disc hits only the center cell
		send_cmd(FN_FILLED, 20'(2 * ONE_CELL), 20'(2 * ONE_CELL), 18'd0, 8'h00, 8'd0, 8'd0);
		send_cmd(FN_READ, 20'd0, 20'd0, 18'd0, 8'd0, 8'd10, 8'd2);
		send_cmd(FN_READ, 20'd0, 20'd0, 18'd0, 8'd0, 8'd14, 8'd6);
		send_cmd(FN_READ, 20'd0, 20'd0, 18'd0, 8'd0, 8'd15, 8'd6);
		send_cmd(FN_READ, 20'd0, 20'd0, 18'd0, 8'd0, 8'd8, 8'd6);
		send_cmd(FN_READ, 20'd0, 20'd0, 18'd0, 8'd0, 8'd15, 8'd3);
		send_cmd(FN_READ, 20'd0, 20'd0, 18'd0, 8'd0, 8'd2, 8'd2);
		send_cmd(FN_READ, 20'd0, 20'd0, 18'd0, 8'd0, 8'd19, 8'd5);
		send_cmd(FN_READ, 20'd0, 20'd0, 18'd0, 8'd0, 8'd0, 8'd11);
		send_cmd(FN_READ, 20'd0, 20'd0, 18'd0, 8'd0, 8'd6, 8'd3);
		// widest disc covers the whole grid
		send_cmd(FN_FILLED, 20'd0, 20'd0, 18'h3FFFF, 8'h55, 8'd0, 8'd0);
		send_cmd(FN_READ, 20'd0, 20'd0, 18'd0, 8'd0, 8'd19, 8'd11);
		send_cmd(FN_READ, 20'd0, 20'd0, 18'd0, 8'd0, 8'd19, 8'd0);
		wait_idle();

		// Random phases over several grid settings
		run_phase(9'd13, 9'd9, 8'($urandom), 10, 6, 1'b0, 1'b0);
		run_phase(9'd1, 9'd1, 8'd0, 8, 4, 1'b0, 1'b0);
		run_phase(9'd256, 9'd256, 8'd255, 8, 2, 1'b0, 1'b0);
		run_phase(9'd0, 9'd5, 8'($urandom), 6, 3, 1'b0, 1'b0);
		run_phase(9'd300, 9'd3, 8'($urandom), 8, 4, 1'b1, 1'b0);
		run_phase(9'd7, 9'd511, 8'($urandom), 8, 4, 1'b0, 1'b0);
		run_phase(9'd1, 9'd256, 8'($urandom), 8, 4, 1'b0, 1'b0);
		run_phase(9'd256, 9'd1, 8'($urandom), 8, 4, 1'b0, 1'b0);
		run_phase(9'd24, 9'd16, 8'($urandom), 12, 6, 1'b0, 1'b1);

		if (board.reads_due.size() != 0) begin
			$error("%0d read words never arrived", board.reads_due.size());
		end
		if (board.errors == 0 && board.reads_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
